### hdl/stripe_offset_to_target_defines.svh
// ----------------------------------------------------------------------------
// stripe offset mapper assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef STRIPE_OFFSET_TO_TARGET_DEFINES_SVH
`define STRIPE_OFFSET_TO_TARGET_DEFINES_SVH

// same-cycle implication
`define SOT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stripe_offset_to_target: assertion failed");

// next-cycle implication
`define SOT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stripe_offset_to_target: assertion failed");

`endif

### hdl/sot_pkg.sv
// ----------------------------------------------------------------------------
// stripe offset mapper package
// field widths, stream packing, register and command codes, stage types
// ----------------------------------------------------------------------------
package sot_pkg;

	localparam int OFFSET_W   = 63;
	localparam int CHUNK_W    = 5;
	localparam int NUM_W      = 6;
	localparam int IDX_W      = 5;
	localparam int ID_W       = 16;
	localparam int R_W        = NUM_W;
	localparam int Q_W        = 64;
	localparam int BITS_PER_CELL = 4;
	localparam int NUM_CELLS  = Q_W / BITS_PER_CELL;

	localparam int S_OFFSET_LSB = 0;
	localparam int S_INDEX_LSB  = S_OFFSET_LSB + OFFSET_W;
	localparam int S_ID_LSB     = S_INDEX_LSB + IDX_W;
	localparam int S_TDATA_W    = ((S_ID_LSB + ID_W + 7) / 8) * 8;
	localparam int M_RES_W      = IDX_W + ID_W;
	localparam int M_TDATA_W    = ((M_RES_W + 7) / 8) * 8;

	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 8;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_MAP  = 1'b1
	} cmd_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CHUNK_SIZE_LOG2 = 2'd0,
		REG_NUM_TARGETS     = 2'd1
	} reg_index_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [Q_W-1:0]   q;
		logic [R_W-1:0]   r;
		logic [IDX_W-1:0] entry_index;
		logic [ID_W-1:0]  entry_id;
	} cell_bus_t;

	typedef struct packed {
		logic [ID_W-1:0]  target_id;
		logic [IDX_W-1:0] target_index;
	} res_t;

endpackage

### hdl/sot_ram.sv
// ----------------------------------------------------------------------------
// sot_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sot_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/sot_cell.sv
// ----------------------------------------------------------------------------
// sot_cell
// one remainder cell: folds the next quotient bits into the running residue
// ----------------------------------------------------------------------------
module sot_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [sot_pkg::R_W-1:0]    n_eff,
	input  logic                       in_valid,
	input  sot_pkg::cell_bus_t         in_bus,
	output logic                       out_valid,
	output sot_pkg::cell_bus_t         out_bus
);

	import sot_pkg::*;

	cell_bus_t      nxt;
	logic [R_W:0]   t;
	logic [R_W-1:0] r;

	always_comb begin
		nxt = in_bus;
		r   = in_bus.r;
		t   = '0;
		for (int k = 0; k < BITS_PER_CELL; k++) begin
			t = {r, in_bus.q[Q_W-1-k]};
			if (t >= {1'b0, n_eff}) begin
				t = t - {1'b0, n_eff};
			end
			r = t[R_W-1:0];
		end
		nxt.r = r;
		nxt.q = in_bus.q << BITS_PER_CELL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_bus <= nxt;
		end
	end

endmodule

### hdl/sot_out_buf.sv
// ----------------------------------------------------------------------------
// sot_out_buf
// two-entry result buffer between the pipeline and the output stream
// ----------------------------------------------------------------------------
module sot_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sot_pkg::res_t push_data,
	input  logic          pop_ready,
	output logic          out_valid,
	output sot_pkg::res_t out_data,
	output logic          room
);

	import sot_pkg::*;

	localparam logic [1:0] FULL = 2'd2;

	logic [1:0] cnt_q;
	res_t       head_q;
	res_t       tail_q;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = head_q;
	assign room      = (cnt_q != FULL);
	assign pop       = out_valid & pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		case (cnt_q)
			2'd0: begin
				if (push) begin
					head_q <= push_data;
				end
			end
			2'd1: begin
				if (push && pop) begin
					head_q <= push_data;
				end else if (push) begin
					tail_q <= push_data;
				end
			end
			default: begin
				if (pop) begin
					head_q <= tail_q;
				end
			end
		endcase
	end

endmodule

### hdl/stripe_offset_to_target.sv
// ----------------------------------------------------------------------------
// stripe_offset_to_target
// maps a file offset to its stripe target index and target id
// ----------------------------------------------------------------------------
// map path: chunk stage, remainder cells, table read, output buffer, then m_tdata
// throughput: one item per cycle unless stalled; 16 remainder cells of 4 bits each
// load items write the table at the end of the chain and give no result
// s_tready drops only while both output buffer slots hold results
// reset: asynchronous, active low; registers back to 16 and 2, table not cleared
// ----------------------------------------------------------------------------
`include "stripe_offset_to_target_defines.svh"

module stripe_offset_to_target #(
	parameter int MAX_TARGETS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// command
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic                             s_tuser,
	// offset, entry_index, entry_id
	input  logic [sot_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// target_index, target_id
	output logic [sot_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sot_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [sot_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import sot_pkg::*;

	localparam int AW = $clog2(MAX_TARGETS);
	localparam int NW = $clog2(MAX_TARGETS + 1);
	localparam int CW = (NW > NUM_W) ? NW : NUM_W;
	localparam int EW = ((AW > IDX_W) ? AW : IDX_W) + 1;
	localparam int RW = (AW > R_W) ? AW : R_W;

	logic [CHUNK_W-1:0] chunk_size_log2_q;
	logic [NUM_W-1:0]   num_targets_q;
	logic [CW-1:0]      num_ext;
	logic [R_W-1:0]     n_eff;

	logic               adv;
	logic               s1_valid_q;
	cell_bus_t          s1_bus_q;
	logic               cell_valid [NUM_CELLS+1];
	cell_bus_t          cell_bus   [NUM_CELLS+1];

	cell_bus_t          tail_bus;
	logic               tail_valid;
	logic [EW-1:0]      wr_ext;
	logic [RW-1:0]      rd_ext;
	logic               ram_we;
	logic               ram_re;
	logic [ID_W-1:0]    ram_rdata;

	logic               t_valid_q;
	logic [IDX_W-1:0]   t_index_q;
	logic               push;
	res_t               push_res;
	res_t               m_res;
	logic               room;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size_log2_q <= CHUNK_W'(16);
			num_targets_q     <= NUM_W'(2);
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_CHUNK_SIZE_LOG2: chunk_size_log2_q <= cfg_data[CHUNK_W-1:0];
				REG_NUM_TARGETS:     num_targets_q     <= cfg_data[NUM_W-1:0];
				default: ;
			endcase
		end
	end

	assign num_ext = CW'(num_targets_q);

	always_comb begin
		if (num_targets_q == '0) begin
			n_eff = R_W'(1);
		end else if (num_ext > CW'(MAX_TARGETS)) begin
			n_eff = R_W'(MAX_TARGETS);
		end else begin
			n_eff = num_targets_q;
		end
	end

	assign adv      = room;
	assign s_tready = adv;

	// chunk number stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s1_bus_q.cmd         <= cmd_t'(s_tuser);
			s1_bus_q.q           <= Q_W'(s_tdata[S_OFFSET_LSB +: OFFSET_W] >> chunk_size_log2_q);
			s1_bus_q.r           <= '0;
			s1_bus_q.entry_index <= s_tdata[S_INDEX_LSB +: IDX_W];
			s1_bus_q.entry_id    <= s_tdata[S_ID_LSB +: ID_W];
		end
	end

	assign cell_valid[0] = s1_valid_q;
	assign cell_bus[0]   = s1_bus_q;

	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
		sot_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.n_eff     (n_eff),
			.in_valid  (cell_valid[g]),
			.in_bus    (cell_bus[g]),
			.out_valid (cell_valid[g+1]),
			.out_bus   (cell_bus[g+1])
		);
	end

	assign tail_valid = cell_valid[NUM_CELLS];
	assign tail_bus   = cell_bus[NUM_CELLS];

	// target table
	assign wr_ext = EW'(tail_bus.entry_index);
	assign rd_ext = RW'(tail_bus.r);
	assign ram_we = adv & tail_valid & (tail_bus.cmd == CMD_LOAD) & (wr_ext < EW'(MAX_TARGETS));
	assign ram_re = adv & tail_valid & (tail_bus.cmd == CMD_MAP);

	sot_ram #(
		.WIDTH (ID_W),
		.DEPTH (MAX_TARGETS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_ext[AW-1:0]),
		.wdata (tail_bus.entry_id),
		.re    (ram_re),
		.raddr (rd_ext[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_valid_q <= 1'b0;
		end else if (adv) begin
			t_valid_q <= tail_valid & (tail_bus.cmd == CMD_MAP);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_index_q <= tail_bus.r[IDX_W-1:0];
		end
	end

	assign push                  = adv & t_valid_q;
	assign push_res.target_index = t_index_q;
	assign push_res.target_id    = ram_rdata;

	sot_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_res),
		.pop_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_res),
		.room      (room)
	);

	assign m_tdata = M_TDATA_W'(m_res);

	`SOT_ASSERT_IMP(a_index_in_set, m_tvalid, R_W'(m_res.target_index) < n_eff)
	`SOT_ASSERT_IMP(a_stall_only_on_wait, !s_tready, m_tvalid)
	`SOT_ASSERT_NXT(a_push_shows, push && !m_tvalid, m_tvalid)

endmodule

### test/stripe_offset_to_target_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stripe_offset_to_target_test
// drives load and map transfers under a series of register settings, including
// zero and oversized target counts and the full chunk shift range, with random
// gaps on both stream sides, and checks every map result against a local
// model of the stripe mapping and the target table
// ----------------------------------------------------------------------------
module stripe_offset_to_target_test;

	import sot_pkg::*;

	localparam int SLOTS = 32;
	localparam int SETTLE_CYCLES = 24;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic                   s_tuser = 1'b0;
	logic [S_TDATA_W-1:0]   s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	logic [CHUNK_W-1:0]     chunk_shift = 5'd16;
	logic [NUM_W-1:0]       target_count = 6'd2;
	logic [ID_W-1:0]        id_table [SLOTS];
	logic [SLOTS-1:0]       slot_loaded = '0;
	res_t                   pending_targets [$];
	int unsigned            mismatch_count = 0;
	bit                     steady = 1'b0;

	stripe_offset_to_target #(
		.MAX_TARGETS(SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady || r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// zero targets act as one, counts above the table size saturate
	function automatic logic [IDX_W-1:0] predict_slot(logic [OFFSET_W-1:0] off);
		logic [63:0] chunk_no;
		logic [63:0] n;
		n = 64'(target_count);
		if (n == 0) begin
			n = 64'd1;
		end
		if (n > SLOTS) begin
			n = 64'(SLOTS);
		end
		chunk_no = {1'b0, off} >> chunk_shift;
		return IDX_W'(chunk_no % n);
	endfunction

	function automatic logic [OFFSET_W-1:0] pick_offset();
		logic [63:0] raw;
		logic [63:0] base;
		int unsigned bits;
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			2, 3: begin
				bits = $urandom_range(1, 62);
				return OFFSET_W'(raw & ((64'd1 << bits) - 64'd1));
			end
			4, 5: begin
				// around a chunk boundary
				base = (raw >> 40) << chunk_shift;
				case ($urandom_range(0, 2))
					0: base = base - 64'd1;
					1: base = base + 64'd1;
					default: ;
				endcase
				return base[OFFSET_W-1:0];
			end
			default: begin
				return raw[OFFSET_W-1:0];
			end
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= 40) begin
			$display("%0t ns: %s", $time, msg);
		end
	endtask

	task automatic send_item(cmd_t cmd, logic [OFFSET_W-1:0] off, logic [IDX_W-1:0] slot,
			logic [ID_W-1:0] id);
		int unsigned gap;
		res_t want;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {{(S_TDATA_W - S_ID_LSB - ID_W){1'b0}}, id, slot, off};
		@(posedge clk iff s_tready === 1'b1);
		if (cmd == CMD_LOAD) begin
			id_table[slot] = id;
			slot_loaded[slot] = 1'b1;
		end else begin
			want.target_index = predict_slot(off);
			want.target_id = id_table[want.target_index];
			pending_targets.push_back(want);
		end
	endtask

	// a map never reads a slot that has not been loaded since reset
	task automatic map_offset(logic [OFFSET_W-1:0] off);
		logic [IDX_W-1:0] slot;
		slot = predict_slot(off);
		if (!slot_loaded[slot]) begin
			send_item(CMD_LOAD, OFFSET_W'({$urandom, $urandom}), slot, ID_W'($urandom));
		end
		send_item(CMD_MAP, off, IDX_W'($urandom), ID_W'($urandom));
	endtask

	task automatic random_item();
		if ($urandom_range(0, 3) == 0) begin
			send_item(CMD_LOAD, OFFSET_W'({$urandom, $urandom}), IDX_W'($urandom),
				ID_W'($urandom));
		end else begin
			map_offset(pick_offset());
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_targets.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_register(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
		wait_drained();
		// loads still in flight give no result
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk iff cfg_ready === 1'b1);
		cfg_valid <= 1'b0;
		if (idx == REG_CHUNK_SIZE_LOG2) begin
			chunk_shift = value[CHUNK_W-1:0];
		end else begin
			target_count = value[NUM_W-1:0];
		end
	endtask

	task automatic test_directed();
		send_item(CMD_LOAD, '0, 5'd0, 16'h0000);
		send_item(CMD_LOAD, '1, 5'd31, 16'hffff);
		send_item(CMD_LOAD, '0, 5'd1, 16'h5a5a);
		map_offset('0);
		map_offset('1);
		map_offset(63'hffff);
		map_offset(63'h10000);
		map_offset(63'h20000);
		write_register(REG_CHUNK_SIZE_LOG2, 8'd0);
		write_register(REG_NUM_TARGETS, 8'd32);
		map_offset(63'd31);
		map_offset(63'd32);
		// zero targets
		write_register(REG_NUM_TARGETS, 8'd0);
		map_offset('1);
		// oversized count and widest chunk shift
		write_register(REG_NUM_TARGETS, 8'd63);
		write_register(REG_CHUNK_SIZE_LOG2, 8'd31);
		map_offset('1);
		map_offset(63'h0000_000f_8000_0000);
	endtask

	task automatic test_random_settings();
		int unsigned shifts [10] = '{0, 31, 26, 16, 5, 12, 1, 20, 31, 0};
		int unsigned counts [10] = '{2, 63, 32, 0, 3, 1, 17, 33, 7, 32};
		for (int p = 0; p < 10; p++) begin
			write_register(REG_CHUNK_SIZE_LOG2, CFG_DATA_W'(shifts[p]));
			write_register(REG_NUM_TARGETS, CFG_DATA_W'(counts[p]));
			steady = (p % 4 == 3);
			repeat (175) random_item();
			steady = 1'b0;
		end
	endtask

	task automatic test_drain_pause();
		write_register(REG_CHUNK_SIZE_LOG2, 8'd3);
		write_register(REG_NUM_TARGETS, 8'd5);
		repeat (5) begin
			repeat (20) random_item();
			wait_drained();
		end
	endtask

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = res_t'(m_tdata[M_RES_W-1:0]);
			if (pending_targets.size() == 0) begin
				report_mismatch($sformatf("result with none pending: index %0d id %h",
					got.target_index, got.target_id));
			end else begin
				want = pending_targets.pop_front();
				if (got.target_index !== want.target_index) begin
					report_mismatch($sformatf("target_index %0d, wanted %0d",
						got.target_index, want.target_index));
				end
				if (got.target_id !== want.target_id) begin
					report_mismatch($sformatf("target_id %h, wanted %h",
						got.target_id, want.target_id));
				end
			end
		end
	end

	initial begin
		int unsigned gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	initial begin
		#20_000_000;
		$display("stripe_offset_to_target_test: errors");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_settings();
		test_drain_pause();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("stripe_offset_to_target_test: clean");
		end else begin
			$display("stripe_offset_to_target_test: errors");
		end
		$finish;
	end

endmodule
